/* rtl/core/fdr_pkg.sv */
`default_nettype none
package fdr_pkg;

  localparam int CHUNK_SLOTS_DEF   = 8;
  localparam int SLOT_BYTES_DEF    = 256;
  localparam int MESSAGE_BYTES_DEF = 2048;

  localparam logic [9:0] HDR_LEN   = 10'd8;
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [3:0] ST_INCOMPLETE = 4'd0;
  localparam logic [3:0] ST_COMPLETE   = 4'd1;
  localparam logic [3:0] ST_GAP        = 4'd2;
  localparam logic [3:0] ST_SHORT      = 4'd3;
  localparam logic [3:0] ST_BAD_MAGIC  = 4'd4;
  localparam logic [3:0] ST_BAD_VER    = 4'd5;
  localparam logic [3:0] ST_SEQ_RANGE  = 4'd6;
  localparam logic [3:0] ST_TOO_LARGE  = 4'd7;
  localparam logic [3:0] ST_READ       = 4'd8;

  localparam logic [1:0] CFG_MAGIC    = 2'd0;
  localparam logic [1:0] CFG_VERSION  = 2'd1;
  localparam logic [1:0] CFG_MAX_BODY = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] msg_id;
    logic [7:0]  msg_type;
    logic [7:0]  total_chunks;
    logic [11:0] full_len;
    logic [7:0]  read_data;
  } out_item_t;

  typedef enum logic [2:0] {
    K_PUSH = 3'b001,
    K_END  = 3'b010,
    K_READ = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [10:0] read_addr;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [8:0] max_body;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/core/fdr_front.sv */
`default_nettype none
module fdr_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  fdr_pkg::in_item_t in_data,
  output logic              q_valid,
  input  wire               q_ready,
  output fdr_pkg::q_entry_t q_entry
);
  import fdr_pkg::*;

  q_entry_t   entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  q_entry_t   e_in;
  logic       push;
  logic       pop;

  always_comb begin
    e_in.data_byte = in_data.data_byte;
    e_in.read_addr = in_data.read_addr;
    if (in_data.op == OP_READ) begin
      e_in.kind = K_READ;
    end else if (in_data.frame_end) begin
      e_in.kind = K_END;
    end else begin
      e_in.kind = K_PUSH;
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = entries[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= e_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/fdr_back.sv */
`default_nettype none
module fdr_back #(
  parameter int CHUNK_SLOTS   = fdr_pkg::CHUNK_SLOTS_DEF,
  parameter int SLOT_BYTES    = fdr_pkg::SLOT_BYTES_DEF,
  parameter int MESSAGE_BYTES = fdr_pkg::MESSAGE_BYTES_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  fdr_pkg::cfg_t      cfg,
  input  wire                q_valid,
  output logic               q_ready,
  input  fdr_pkg::q_entry_t  q_entry,
  output logic               out_valid,
  input  wire                out_ready,
  output fdr_pkg::out_item_t out_data
);
  import fdr_pkg::*;

  localparam int SIW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int CW  = $clog2(CHUNK_SLOTS + 1);
  localparam int AW  = $clog2(CHUNK_SLOTS * SLOT_BYTES);
  localparam int BLW = $clog2(SLOT_BYTES + 1);
  localparam int LW  = $clog2(MESSAGE_BYTES + 1);
  localparam int MAW = $clog2(MESSAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_COPY = 3'b100
  } state_t;

  state_t                 state;
  logic [CHUNK_SLOTS-1:0] present;
  logic [CW-1:0]          rcount;
  logic [15:0]            held_id;
  logic [7:0]             held_type;
  logic [7:0]             held_total;
  logic [7:0]             hdr [8];
  logic [9:0]             fcount;
  logic [LW-1:0]          msg_len;
  logic [BLW-1:0]         clen [CHUNK_SLOTS];
  logic [CW-1:0]          ci;
  logic [CW-1:0]          lim;
  logic [BLW-1:0]         bj;
  logic [LW-1:0]          off;
  logic                   pend;
  logic [MAW-1:0]         pend_dst;
  logic                   hit_q;

  logic [7:0]             store [CHUNK_SLOTS*SLOT_BYTES];
  logic [7:0]             cs_q;
  logic [7:0]             mbuf [MESSAGE_BYTES];
  logic [7:0]             mb_q;

  logic                   pop;
  logic                   is_read;
  logic                   is_end;
  logic [7:0]             hdr_eff [8];
  logic [9:0]             cnt_inc;
  logic [9:0]             blen;
  logic [7:0]             seq;
  logic                   seq_ok;
  logic [SIW-1:0]         seq_idx;
  logic                   id_sw;
  logic                   body_wr;
  logic [AW-1:0]          st_wa;
  logic [CHUNK_SLOTS-1:0] pres_e;
  logic [CW-1:0]          cnt_e;
  logic                   is_new;
  logic [CW-1:0]          cnt2;
  logic                   hdr_ok;
  logic                   fin_store;
  logic                   fin_copy;
  logic [3:0]             fin_status;
  logic [CW-1:0]          lim_init;
  logic [15:0]            id_out;
  logic [7:0]             type_out;
  logic [7:0]             total_out;
  logic                   rd_hit;
  logic [SIW-1:0]         cur;
  logic                   at_end;
  logic                   issue;
  logic [AW-1:0]          cs_ra;

  assign q_ready = (state == S_IDLE) && !out_valid;
  assign pop     = q_valid && q_ready;
  assign is_read = (q_entry.kind == K_READ);
  assign is_end  = (q_entry.kind == K_END);

  // the byte in flight may itself complete the header
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      hdr_eff[k] = (fcount < HDR_LEN && fcount[2:0] == 3'(k)) ? q_entry.data_byte : hdr[k];
    end
  end

  assign cnt_inc  = (fcount == COUNT_MAX) ? fcount : fcount + 10'd1;
  assign blen     = cnt_inc - HDR_LEN;
  assign seq      = hdr_eff[6];
  assign seq_ok   = 32'(seq) < CHUNK_SLOTS;
  assign seq_idx  = SIW'(seq);
  assign id_sw    = (rcount != '0) && ({hdr_eff[4], hdr_eff[5]} != held_id);

  assign body_wr = !is_read && (fcount >= HDR_LEN)
                && ((32'(fcount) - 32'(HDR_LEN)) < SLOT_BYTES)
                && (hdr[0] == cfg.magic) && (hdr[1] == cfg.version)
                && seq_ok && (!present[seq_idx] || id_sw);
  assign st_wa = AW'(32'(seq_idx) * SLOT_BYTES + 32'(fcount) - 32'(HDR_LEN));

  assign pres_e = id_sw ? '0 : present;
  assign cnt_e  = id_sw ? '0 : rcount;
  assign is_new = seq_ok && !pres_e[seq_idx];
  assign cnt2   = cnt_e + CW'(is_new);
  assign lim_init = (32'(hdr_eff[7]) < CHUNK_SLOTS) ? CW'(hdr_eff[7]) : CW'(CHUNK_SLOTS);

  always_comb begin
    hdr_ok     = 1'b0;
    fin_store  = 1'b0;
    fin_copy   = 1'b0;
    fin_status = ST_INCOMPLETE;
    priority if (cnt_inc < HDR_LEN) begin
      fin_status = ST_SHORT;
    end else if (hdr_eff[0] != cfg.magic) begin
      fin_status = ST_BAD_MAGIC;
    end else if (hdr_eff[1] != cfg.version) begin
      fin_status = ST_BAD_VER;
    end else begin
      hdr_ok = 1'b1;
      priority if (!seq_ok) begin
        fin_status = ST_SEQ_RANGE;
      end else if (blen > {1'b0, cfg.max_body} || 32'(blen) > SLOT_BYTES) begin
        fin_status = ST_TOO_LARGE;
      end else begin
        fin_store = 1'b1;
        if (32'(cnt2) >= 32'(hdr_eff[7])) fin_copy = 1'b1;
      end
    end
  end

  assign id_out    = hdr_ok ? {hdr_eff[4], hdr_eff[5]} : held_id;
  assign type_out  = hdr_ok ? hdr_eff[2] : held_type;
  assign total_out = hdr_ok ? hdr_eff[7] : held_total;
  assign rd_hit    = 32'(q_entry.read_addr) < 32'(msg_len);

  assign cur    = SIW'(ci);
  assign at_end = (ci == lim);
  assign issue  = !at_end && present[cur] && (32'(bj) < 32'(clen[cur]))
               && (32'(off) < MESSAGE_BYTES);
  assign cs_ra  = AW'(32'(cur) * SLOT_BYTES + 32'(bj));

  always_ff @(posedge clk) begin
    if (pop && body_wr) begin
      store[st_wa] <= q_entry.data_byte;
    end
    cs_q <= store[cs_ra];
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      mbuf[pend_dst] <= cs_q;
    end
    mb_q <= mbuf[MAW'(q_entry.read_addr)];
  end

  always_ff @(posedge clk) begin
    if (pop && is_end && fin_store && is_new) begin
      clen[seq_idx] <= BLW'(blen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      present    <= '0;
      rcount     <= '0;
      held_id    <= '0;
      held_type  <= '0;
      held_total <= '0;
      fcount     <= '0;
      msg_len    <= '0;
      pend       <= 1'b0;
      pend_dst   <= '0;
      hit_q      <= 1'b0;
      ci         <= '0;
      lim        <= '0;
      bj         <= '0;
      off        <= '0;
      out_valid  <= 1'b0;
      out_data   <= '0;
      for (int k = 0; k < 8; k++) hdr[k] <= '0;
    end else begin
      pend <= (state == S_COPY) && issue;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (is_read) begin
              hit_q <= rd_hit;
              state <= S_READ;
            end else begin
              if (fcount < HDR_LEN) hdr[fcount[2:0]] <= q_entry.data_byte;
              if (!is_end) begin
                fcount <= cnt_inc;
              end else begin
                fcount <= '0;
                if (hdr_ok) begin
                  held_id    <= id_out;
                  held_type  <= type_out;
                  held_total <= total_out;
                end
                if (fin_store && is_new) begin
                  present <= pres_e | (CHUNK_SLOTS'(1) << seq_idx);
                  rcount  <= cnt2;
                end else if (hdr_ok) begin
                  present <= pres_e;
                  rcount  <= cnt_e;
                end
                if (fin_copy) begin
                  state <= S_COPY;
                  ci    <= '0;
                  bj    <= '0;
                  off   <= '0;
                  lim   <= lim_init;
                end else begin
                  out_valid <= 1'b1;
                  out_data  <= '{status: fin_status, msg_id: id_out, msg_type: type_out,
                                 total_chunks: total_out, full_len: 12'(msg_len),
                                 read_data: 8'd0};
                end
              end
            end
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_data  <= '{status: ST_READ, msg_id: held_id, msg_type: held_type,
                         total_chunks: held_total, full_len: 12'(msg_len),
                         read_data: hit_q ? mb_q : 8'd0};
          state     <= S_IDLE;
        end
        S_COPY: begin
          priority if (at_end) begin
            msg_len   <= off;
            out_valid <= 1'b1;
            out_data  <= '{status: ST_COMPLETE, msg_id: held_id, msg_type: held_type,
                           total_chunks: held_total, full_len: 12'(off),
                           read_data: 8'd0};
            state     <= S_IDLE;
          end else if (!present[cur]) begin
            out_valid <= 1'b1;
            out_data  <= '{status: ST_GAP, msg_id: held_id, msg_type: held_type,
                           total_chunks: held_total, full_len: 12'(msg_len),
                           read_data: 8'd0};
            state     <= S_IDLE;
          end else if (issue) begin
            pend_dst <= MAW'(off);
            bj       <= bj + BLW'(1);
            off      <= off + LW'(1);
          end else begin
            // advance to the next chunk
            ci <= ci + CW'(1);
            bj <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(rcount) == $countones(present))
    else $error("chunk count out of step with presence bits");

  a_copy_write_src: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(state == S_COPY))
    else $error("buffer write outside the copy pass");

  a_copy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> !out_valid)
    else $error("result pending during copy pass");

  a_read_from_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(pop))
    else $error("read reply without a dequeued item");
`endif

endmodule
`default_nettype wire

/* rtl/core/frame_decode_reassembler.sv */
`default_nettype none
// Frame decoder and message reassembler.
// in channel (in_valid/in_ready/in_data): op 0 pushes one raw frame byte, with
// frame_end on the last byte of a frame; op 1 reads one assembled message byte.
// out channel (out_valid/out_ready/out_data): one item per frame end and per
// read, none for other pushes.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
// magic, 1 version, 2 max body length. Write only while the block is idle.
// Items pass a two-entry queue and are executed one at a time by the back end,
// which takes a new item only when the output register is empty.
// A read goes through the S_READ state, which registers the reply from the message
// buffer. A frame that completes a message runs the copy pass, which moves chunk
// bytes through the single chunk store read port into the message buffer.
// With out_ready high, plain pushes go at one item per cycle, while a frame end
// or a read holds the back end until its result is taken.
// When out_ready is low the result holds, the back end stops, and the queue
// fills and then drops in_ready.
// Reset clears configuration to defaults, the chunk presence bits, counters,
// held header fields and the message length; stores need no clearing pass.
module frame_decode_reassembler #(
  parameter int CHUNK_SLOTS   = fdr_pkg::CHUNK_SLOTS_DEF,
  parameter int SLOT_BYTES    = fdr_pkg::SLOT_BYTES_DEF,
  parameter int MESSAGE_BYTES = fdr_pkg::MESSAGE_BYTES_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  fdr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output fdr_pkg::out_item_t out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [8:0]          cfg_data
);
  import fdr_pkg::*;

  cfg_t     cfg;
  logic     q_valid;
  logic     q_ready;
  q_entry_t q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic    <= 8'd0;
      cfg.version  <= 8'd1;
      cfg.max_body <= 9'd242;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC:    cfg.magic    <= cfg_data[7:0];
        CFG_VERSION:  cfg.version  <= cfg_data[7:0];
        CFG_MAX_BODY: cfg.max_body <= cfg_data;
        default: ;
      endcase
    end
  end

  fdr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  fdr_back #(
    .CHUNK_SLOTS   (CHUNK_SLOTS),
    .SLOT_BYTES    (SLOT_BYTES),
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* tb/sv/frame_decode_reassembler_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module frame_decode_reassembler_tb;
  import fdr_pkg::*;

  localparam int SLOTS      = 8;
  localparam int SLOT_SIZE  = 256;
  localparam int MSG_SIZE   = 2048;
  localparam int TAIL_WAIT  = 3000;
  localparam int CYCLE_CAP  = 4000000;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  frame_decode_reassembler i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // reassembler mirror
  logic [7:0]  chunk_mem [SLOTS*SLOT_SIZE];
  int          slot_len [SLOTS];
  bit          present [SLOTS];
  int          rx_count;
  logic [15:0] cur_id;
  logic [7:0]  cur_type;
  logic [7:0]  cur_total;
  logic [63:0] hdr_bytes;
  int          byte_cnt;
  logic [7:0]  msg_mem [MSG_SIZE];
  int          msg_len;
  logic [7:0]  magic_cfg;
  logic [7:0]  version_cfg;
  int          max_body_cfg;

  out_item_t   expected_results[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          completions = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [15:0] gen_id;
  int          gen_total;
  out_item_t   want;

  function automatic logic [7:0] hb(input int k);
    return hdr_bytes[8*k +: 8];
  endfunction

  function automatic bit id_switches();
    return rx_count > 0 && {hb(4), hb(5)} != cur_id;
  endfunction

  function automatic bit slot_ok();
    if (hb(0) != magic_cfg || hb(1) != version_cfg) return 0;
    if (hb(6) >= SLOTS) return 0;
    return !present[hb(6)] || id_switches();
  endfunction

  function automatic logic [3:0] close_frame(input int len);
    int seq;
    int body;
    int off;
    int n;
    if (len < 8) return ST_SHORT;
    if (hb(0) != magic_cfg) return ST_BAD_MAGIC;
    if (hb(1) != version_cfg) return ST_BAD_VER;
    if (id_switches()) begin
      foreach (present[i]) present[i] = 0;
      rx_count = 0;
    end
    cur_id = {hb(4), hb(5)};
    cur_type = hb(2);
    cur_total = hb(7);
    seq = hb(6);
    body = len - 8;
    if (seq >= SLOTS) return ST_SEQ_RANGE;
    if (body > max_body_cfg || body > SLOT_SIZE) return ST_TOO_LARGE;
    if (!present[seq]) begin
      slot_len[seq] = body;
      present[seq] = 1;
      rx_count++;
    end
    if (rx_count < cur_total) return ST_INCOMPLETE;
    off = 0;
    for (int i = 0; i < cur_total && i < SLOTS; i++) begin
      if (!present[i]) return ST_GAP;
      n = slot_len[i] < MSG_SIZE - off ? slot_len[i] : MSG_SIZE - off;
      for (int j = 0; j < n; j++) msg_mem[off + j] = chunk_mem[i*SLOT_SIZE + j];
      off += n;
    end
    msg_len = off;
    return ST_COMPLETE;
  endfunction

  // update the mirror; returns 1 when the item yields a result
  function automatic bit predict(input in_item_t x, output out_item_t r);
    int cnt;
    logic [3:0] st;
    logic [7:0] rd;
    rd = 8'd0;
    r = '0;
    if (x.op == OP_READ) begin
      if (x.read_addr < msg_len) rd = msg_mem[x.read_addr];
      st = ST_READ;
    end else begin
      cnt = byte_cnt;
      if (cnt < 8) hdr_bytes[8*cnt +: 8] = x.data_byte;
      else if (cnt - 8 < SLOT_SIZE && slot_ok())
        chunk_mem[int'(hb(6))*SLOT_SIZE + cnt - 8] = x.data_byte;
      if (cnt < 1023) cnt++;
      if (!x.frame_end) begin
        byte_cnt = cnt;
        return 0;
      end
      st = close_frame(cnt);
      byte_cnt = 0;
      hdr_bytes = '0;
    end
    r = '{st, cur_id, cur_type, cur_total, msg_len[11:0], rd};
    return 1;
  endfunction

  task automatic report(input string what, input int got, input int exp);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, exp);
    errors++;
  endtask

  // send one item; a typed result, when given, replaces the predicted one
  task automatic send(input in_item_t x, input bit typed = 0, input out_item_t tres = '0);
    out_item_t r;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    if (predict(x, r)) expected_results.push_back(typed ? tres : r);
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [7:0] m, input logic [7:0] v, input logic [8:0] mb);
    logic [8:0] vals [3];
    logic [1:0] idx [3];
    vals = '{{1'b0, m}, {1'b0, v}, mb};
    idx = '{CFG_MAGIC, CFG_VERSION, CFG_MAX_BODY};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    magic_cfg = m;
    version_cfg = v;
    max_body_cfg = mb;
  endtask

  task automatic push_bytes(input logic [7:0] bytes[$]);
    in_item_t x;
    foreach (bytes[i]) begin
      x.op = OP_PUSH;
      x.data_byte = bytes[i];
      x.frame_end = (i == bytes.size() - 1);
      x.read_addr = 11'($urandom);
      send(x);
    end
  endtask

  task automatic read_burst();
    in_item_t x;
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      x.op = OP_READ;
      x.data_byte = 8'($urandom);
      x.frame_end = 1'($urandom);
      x.read_addr = $urandom_range(0, 99) < 70 ? 11'($urandom_range(0, msg_len + 3))
                                               : 11'($urandom);
      send(x);
    end
  endtask

  task automatic random_frame(input int body_override = -1);
    logic [7:0] f[$];
    int r;
    int len;
    int seq;
    int cap;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      len = $urandom_range(1, 7);
      repeat (len) f.push_back(8'($urandom));
      push_bytes(f);
      return;
    end
    if ($urandom_range(0, 99) < 15) begin
      r = $urandom_range(0, 99);
      gen_id = r < 10 ? 16'h0000 : r < 20 ? 16'hffff : 16'($urandom);
      r = $urandom_range(0, 99);
      gen_total = r < 5 ? 0 : r < 8 ? $urandom_range(9, 255)
                                    : $urandom_range(1, $urandom_range(1, 8));
    end
    r = $urandom_range(0, 99);
    f.push_back(r < 4 ? magic_cfg ^ 8'($urandom_range(1, 255)) : magic_cfg);
    f.push_back(r >= 4 && r < 7 ? version_cfg ^ 8'($urandom_range(1, 255)) : version_cfg);
    f.push_back(8'($urandom));
    f.push_back(8'($urandom));
    f.push_back(gen_id[15:8]);
    f.push_back(gen_id[7:0]);
    cap = gen_total < 1 ? 1 : gen_total > SLOTS ? SLOTS : gen_total;
    seq = $urandom_range(0, 99) < 4 ? $urandom_range(8, 255) : $urandom_range(0, cap - 1);
    f.push_back(8'(seq));
    f.push_back(8'(gen_total));
    r = $urandom_range(0, 99);
    if (body_override >= 0) len = body_override;
    else if (r < 3) len = max_body_cfg + 1 + $urandom_range(0, 3);
    else if (r < 5) len = $urandom_range(max_body_cfg > 200 ? 200 : 0, max_body_cfg);
    else len = $urandom_range(0, max_body_cfg < 24 ? max_body_cfg : 24);
    repeat (len) f.push_back(8'($urandom));
    push_bytes(f);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_frame);
    int start;
    bit paused;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    paused = 0;
    if (long_frame) random_frame(1022);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 20) read_burst();
      else random_frame();
      if (!paused && items_sent - start > PHASE_ITEMS / 2) begin
        drain();
        paused = 1;
      end
    end
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected result, status", out_data.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (want.status == ST_COMPLETE) completions++;
        if (out_data.status !== want.status) report("status", out_data.status, want.status);
        if (out_data.msg_id !== want.msg_id) report("msg_id", out_data.msg_id, want.msg_id);
        if (out_data.msg_type !== want.msg_type)
          report("msg_type", out_data.msg_type, want.msg_type);
        if (out_data.total_chunks !== want.total_chunks)
          report("total_chunks", out_data.total_chunks, want.total_chunks);
        if (out_data.full_len !== want.full_len)
          report("full_len", out_data.full_len, want.full_len);
        if (out_data.read_data !== want.read_data)
          report("read_data", out_data.read_data, want.read_data);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    out_item_t zero_res;
    logic [7:0] hdr_q[$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAGIC;
    cfg_data = '0;
    foreach (present[i]) present[i] = 0;
    foreach (slot_len[i]) slot_len[i] = 0;
    rx_count = 0;
    cur_id = '0;
    cur_type = '0;
    cur_total = '0;
    hdr_bytes = '0;
    byte_cnt = 0;
    msg_len = 0;
    magic_cfg = 8'd0;
    version_cfg = 8'd1;
    max_body_cfg = 242;
    gen_id = 16'h1234;
    gen_total = 3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset configuration
    zero_res = '0;
    rows.push_back('{'{OP_READ, 8'h00, 1'b0, 11'd0}, 1,
                     '{ST_READ, 16'h0, 8'h0, 8'h0, 12'h0, 8'h0}});
    rows.push_back('{'{OP_READ, 8'hff, 1'b1, 11'h7ff}, 1,
                     '{ST_READ, 16'h0, 8'h0, 8'h0, 12'h0, 8'h0}});
    rows.push_back('{'{OP_PUSH, 8'hff, 1'b1, 11'h7ff}, 1,
                     '{ST_SHORT, 16'h0, 8'h0, 8'h0, 12'h0, 8'h0}});
    hdr_q = '{8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (hdr_q[i]) rows.push_back('{'{OP_PUSH, hdr_q[i], 1'(i == 7), 11'd0}, i == 7,
                                        '{ST_BAD_MAGIC, 16'h0, 8'h0, 8'h0, 12'h0, 8'h0}});
    hdr_q = '{8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (hdr_q[i]) rows.push_back('{'{OP_PUSH, hdr_q[i], 1'(i == 7), 11'd0}, i == 7,
                                        '{ST_BAD_VER, 16'h0, 8'h0, 8'h0, 12'h0, 8'h0}});
    hdr_q = '{8'h00, 8'h01, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'h01, 8'hff};
    foreach (hdr_q[i]) rows.push_back('{'{OP_PUSH, hdr_q[i], 1'(i == 8), 11'd0}, 0,
                                        zero_res});
    rows.push_back('{'{OP_READ, 8'h00, 1'b0, 11'd0}, 0, zero_res});
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].res);
    drain();

    cfg_set(8'h00, 8'h01, 9'd242);
    run_phase(0, 0, 1);
    cfg_set(8'hff, 8'h00, 9'd256);
    run_phase(83, 0, 0);
    cfg_set(8'h5a, 8'hff, 9'd0);
    run_phase(0, 83, 0);
    cfg_set(8'($urandom), 8'($urandom), 9'($urandom_range(9, 256)));
    run_phase(21, 21, 0);

    $display("sent %0d items, checked %0d results, %0d completed messages",
             items_sent, results_seen, completions);
    $display("covered four configurations and four idle/stall mixes");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/fdr_pkg.sv
rtl/core/fdr_front.sv
rtl/core/fdr_back.sv
rtl/core/frame_decode_reassembler.sv
tb/sv/frame_decode_reassembler_tb.sv
